### design/assert_macros.svh
// assertion macros shared by the list core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(cond), msg)

`endif

### design/alist_pkg.sv
// types and constants shared by the list core modules
`default_nettype none

package alist_pkg;

   // default sizing
   localparam int CAPACITY_DEFAULT  = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   // fixed field widths of the channels
   localparam int VALUE_BITS       = 32;
   localparam int COUNT_FIELD_BITS = 7;

   // operation codes
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_LIST   = 2'd3
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // source of the result value
   typedef enum logic [1:0] {
      EMIT_VALUE,
      EMIT_ENTRY,
      EMIT_ZERO
   } emit_sel_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_LIST_RD,
      S_LIST_OUT
   } state_type;

   // request word
   typedef struct packed {
      mode_type                       mode;
      logic signed [VALUE_BITS-1:0]   value;
   } req_type;

   // response word
   typedef struct packed {
      status_type                     status;
      logic signed [VALUE_BITS-1:0]   item_value;
      logic [COUNT_FIELD_BITS-1:0]    entry_count;
      logic                           last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic         load_req;
      logic         idx_clr;
      logic         idx_inc;
      logic         wr_ins;
      logic         wr_shift;
      logic         cnt_dec;
      logic         emit;
      emit_sel_type emit_sel;
      status_type   emit_status;
      logic         emit_last;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      mode_type mode;
      logic     count_zero;
      logic     full;
      logic     match;
      logic     idx_last;
   } dp_stat_type;

endpackage

`default_nettype wire

### design/alist_datapath.sv
// datapath: entry store, count, scan index and response register
`default_nettype none

module alist_datapath #(
   parameter int CAPACITY  = alist_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = alist_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire alist_pkg::req_type    req_word,
   input  wire alist_pkg::ctl_cmd_type cmd,
   output alist_pkg::dp_stat_type     stat,
   output logic                       rsp_strobe,
   output alist_pkg::rsp_type         rsp_word
);
   import alist_pkg::*;

`include "assert_macros.svh"

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [WORD_BITS-1:0]  mem [CAPACITY];
   mode_type              mode_ff;
   logic [VALUE_BITS-1:0] raw_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [WORD_BITS-1:0]  word_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [IDX_BITS-1:0]   idx_in;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [VALUE_BITS-1:0] entry_narrow;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   // sign-extend or truncate the request value to the stored word width
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         word_in[b] = req_word.value[(b < VALUE_BITS) ? b : VALUE_BITS - 1];
      end
   end

   // stored word back to the value field width
   always_comb begin
      for (int b = 0; b < VALUE_BITS; b++) begin
         entry_narrow[b] = rd_data_ff[(b < WORD_BITS) ? b : WORD_BITS - 1];
      end
   end

   // latched request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_word.mode;
         raw_ff  <= req_word.value;
         word_ff <= word_in;
      end
   end

   // entry count and scan index next values
   always_comb begin
      count_in = count_ff;
      if (cmd.wr_ins) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   // entry store: one write port, one registered read port at the scan index
   always_ff @(posedge clock) begin
      if (cmd.wr_ins) begin
         mem[count_ff[IDX_BITS-1:0]] <= word_ff;
      end else if (cmd.wr_shift) begin
         mem[idx_ff - IDX_BITS'(1)] <= rd_data_ff;
      end
      rd_data_ff <= mem[idx_ff];
   end

   // status towards the controller
   always_comb begin
      stat.mode       = mode_ff;
      stat.count_zero = (count_ff == '0);
      stat.full       = (count_ff == CNT_BITS'(CAPACITY));
      stat.match      = (rd_data_ff == word_ff);
      stat.idx_last   = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == count_ff);
   end

   // response word
   always_comb begin
      rsp_in.status      = cmd.emit_status;
      rsp_in.entry_count = COUNT_FIELD_BITS'(count_in);
      rsp_in.last        = cmd.emit_last;
      case (cmd.emit_sel)
         EMIT_ENTRY: rsp_in.item_value = entry_narrow;
         EMIT_ZERO:  rsp_in.item_value = '0;
         default:    rsp_in.item_value = raw_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // checks
   `ASSERT_NEVER(a_ins_when_full, clock, reset, cmd.wr_ins && stat.full, "insert into full store")
   `ASSERT_NEVER(a_dec_when_empty, clock, reset, cmd.cnt_dec && stat.count_zero, "count underflow")
   `ASSERT_CLK(a_count_hold, clock, reset, (!$past(reset) && !$past(cmd.wr_ins) && !$past(cmd.cnt_dec)) |-> $stable(count_ff), "count moved without command")

endmodule

`default_nettype wire

### design/alist_controller.sv
// controller: sequences insert, scan, shift and list steps
`default_nettype none

module alist_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire alist_pkg::dp_stat_type stat,
   output alist_pkg::ctl_cmd_type      cmd,
   output logic                        busy
);
   import alist_pkg::*;

`include "assert_macros.svh"

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.mode == MODE_INSERT || stat.count_zero) begin
               state_in = S_IDLE;
            end else if (stat.mode == MODE_LIST) begin
               state_in = S_LIST_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (stat.match) begin
               if (stat.mode == MODE_DELETE && !stat.idx_last) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (stat.idx_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = stat.idx_last ? S_IDLE : S_SHIFT_RD;
         S_LIST_RD:  state_in = S_LIST_OUT;
         S_LIST_OUT: state_in = stat.idx_last ? S_IDLE : S_LIST_RD;
         default:    state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd             = '0;
      cmd.emit_sel    = EMIT_VALUE;
      cmd.emit_status = ST_DONE;
      cmd.emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               cmd.idx_clr  = 1'b1;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_INSERT: begin
                  cmd.emit = 1'b1;
                  if (stat.full) begin
                     cmd.emit_status = ST_FULL;
                  end else begin
                     cmd.wr_ins = 1'b1;
                  end
               end
               MODE_DELETE: begin
                  if (stat.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_EMPTY;
                  end
               end
               MODE_SEARCH: begin
                  if (stat.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_NOT_FOUND;
                  end
               end
               default: begin
                  // list of an empty store gives one empty word
                  if (stat.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_EMPTY;
                     cmd.emit_sel    = EMIT_ZERO;
                  end
               end
            endcase
         end
         S_SCAN_CMP: begin
            if (stat.match) begin
               if (stat.mode == MODE_DELETE) begin
                  if (stat.idx_last) begin
                     cmd.emit    = 1'b1;
                     cmd.cnt_dec = 1'b1;
                  end else begin
                     cmd.idx_inc = 1'b1;
                  end
               end else begin
                  cmd.emit = 1'b1;
               end
            end else if (stat.idx_last) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_NOT_FOUND;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SHIFT_WR: begin
            // move entry at the index down by one place
            cmd.wr_shift = 1'b1;
            if (stat.idx_last) begin
               cmd.emit    = 1'b1;
               cmd.cnt_dec = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_LIST_OUT: begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_ENTRY;
            cmd.emit_last = stat.idx_last;
            cmd.idx_inc   = !stat.idx_last;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // checks
   `ASSERT_NEVER(a_idle_no_write, clock, reset, !busy && (cmd.wr_shift || cmd.cnt_dec || cmd.wr_ins), "store command while idle")
   `ASSERT_CLK(a_last_ends_item, clock, reset, (cmd.emit && cmd.emit_last) |=> (state_ff == S_IDLE), "final word did not end the item")
   `ASSERT_CLK(a_busy_after_start, clock, reset, (start && !busy) |=> busy, "start not taken")

endmodule

`default_nettype wire

### design/array_list_insert_delete_search_core.sv
// top level of the unsorted array list core
//
// Usage: present an operation on req_word and raise start; the word is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the last response word of that operation has been issued.
// Each response word is on rsp_word for one cycle with rsp_strobe high;
// the receiver cannot hold responses off. An accepted operation goes to
// dispatch; insert ends there, as do the others on an empty store.
// Search reads and compares entries in turn until a hit or the last of
// the n stored entries; delete scans the same way and, after a hit at
// position p, reads each later entry and writes it one place down. List
// reads and shows the entries in turn, one word each. Scan and shift
// read each entry from the single store port and use it the next cycle.
// A new operation may be accepted in the cycle its last word is shown.
// Reset clears the entry count and the controller; the store contents are
// left as they are, since only entries below the count are ever used.
`default_nettype none

module array_list_insert_delete_search_core #(
   parameter int CAPACITY  = alist_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = alist_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire alist_pkg::req_type req_word,
   output logic                    rsp_strobe,
   output alist_pkg::rsp_type      rsp_word
);
   import alist_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer
   alist_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // store, count and response register
   alist_datapath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
